// ===== hw/rtl/msp_pkg.sv =====
// Shared types and constants for the multi-stack shared-pool block.
`timescale 1ns / 1ps

package msp_pkg;

  localparam int NUM_STACKS_DEF = 4;
  localparam int CAPACITY_DEF   = 64;
  localparam int SEL_W          = 2;
  localparam int DATA_W         = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

// ===== hw/rtl/multi_stack_shared_pool.sv =====
// Top level: several LIFO stacks sharing one linked slot store with a free list.
//
//   port group     dir  handshake            payload
//   command        in   start_i & !busy_o    operation_i, stack_select_i, push_value_i
//   result         out  result_valid_o       pop_value_o, status_o
//
// For each word, the accept cycle issues the memory reads, and the
// next cycle updates the heads, writes the slot memories back and strobes the
// result. busy_o is high in that update cycle, so a new word is not taken
// until the last one is through; the registered memory read sets this.
// Reset leaves every stack empty and the free list in slot order; slots never
// allocated get their implicit link from a fill count, so no clearing pass runs.
// The receiver cannot stall: the result strobe is high for exactly one cycle.
`timescale 1ns / 1ps

module multi_stack_shared_pool #(
  parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int CAPACITY   = msp_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [msp_pkg::SEL_W-1:0]     stack_select_i,
  input  logic [msp_pkg::DATA_W-1:0]    push_value_i,
  output logic                          result_valid_o,
  output logic [msp_pkg::DATA_W-1:0]    pop_value_o,
  output logic [msp_pkg::STATUS_W-1:0]  status_o
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW  = $clog2(CAPACITY + 1);
  localparam int HIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);

  msp_pkg::state_e state_q, state_d;

  logic [msp_pkg::DATA_W-1:0] data_mem [CAPACITY];
  logic [LW-1:0]              link_mem [CAPACITY];
  logic [msp_pkg::DATA_W-1:0] data_rd_q;
  logic [LW-1:0]              link_rd_q;

  logic [LW-1:0]  stack_head_q [NUM_STACKS];
  logic [LW-1:0]  free_head_q;
  logic [LW-1:0]  fill_q;

  logic                       op_q;
  logic [HIW-1:0]             sel_q;
  logic [LW-1:0]              slot_q;
  logic [msp_pkg::DATA_W-1:0] val_q;
  msp_pkg::status_e           status_q;

  logic                       accept;
  logic                       sel_ok;
  logic [HIW-1:0]             sel_idx;
  logic [LW-1:0]              head_cur;
  logic [LW-1:0]              rd_slot;
  logic                       rd_fail;
  msp_pkg::status_e           status_new;
  logic [LW-1:0]              link_eff;
  logic                       commit;

  assign accept   = start_i && (state_q == msp_pkg::ST_IDLE);
  assign sel_ok   = 32'(stack_select_i) < 32'(NUM_STACKS);
  assign sel_idx  = HIW'(stack_select_i);
  assign head_cur = sel_ok ? stack_head_q[sel_idx] : LINK_NULL;
  assign rd_slot  = (operation_i == msp_pkg::OP_PUSH) ? free_head_q : head_cur;
  assign rd_fail  = !sel_ok || (rd_slot == LINK_NULL);

  always_comb begin
    if (!rd_fail) begin
      status_new = msp_pkg::STATUS_OK;
    end else if (operation_i == msp_pkg::OP_PUSH) begin
      status_new = msp_pkg::STATUS_OVERFLOW;
    end else begin
      status_new = msp_pkg::STATUS_UNDERFLOW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !rd_fail) begin
      data_rd_q <= data_mem[rd_slot[AW-1:0]];
      link_rd_q <= link_mem[rd_slot[AW-1:0]];
    end
  end

  // slots at or above the fill count were never allocated and link to the next slot
  assign link_eff = (slot_q < fill_q) ? link_rd_q : slot_q + LW'(1);
  assign commit   = (state_q == msp_pkg::ST_EXEC) && (status_q == msp_pkg::STATUS_OK);

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (op_q == msp_pkg::OP_PUSH) begin
        data_mem[slot_q[AW-1:0]] <= val_q;
        link_mem[slot_q[AW-1:0]] <= stack_head_q[sel_q];
      end else begin
        link_mem[slot_q[AW-1:0]] <= free_head_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      sel_q    <= sel_idx;
      slot_q   <= rd_slot;
      val_q    <= push_value_i;
      status_q <= status_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head_q[i] <= LINK_NULL;
      end
      free_head_q <= '0;
      fill_q      <= '0;
    end else if (commit) begin
      if (op_q == msp_pkg::OP_PUSH) begin
        free_head_q         <= link_eff;
        stack_head_q[sel_q] <= slot_q;
        if (slot_q == fill_q) begin
          fill_q <= fill_q + LW'(1);
        end
      end else begin
        stack_head_q[sel_q] <= link_eff;
        free_head_q         <= slot_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    busy_o         = 1'b0;
    result_valid_o = 1'b0;
    pop_value_o    = '0;
    status_o       = msp_pkg::STATUS_OK;
    case (state_q)
      msp_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = msp_pkg::ST_EXEC;
        end
      end
      msp_pkg::ST_EXEC: begin
        busy_o         = 1'b1;
        result_valid_o = 1'b1;
        status_o       = status_q;
        if (commit && (op_q == msp_pkg::OP_POP)) begin
          pop_value_o = data_rd_q;
        end
        state_d = msp_pkg::ST_IDLE;
      end
      default: begin
        state_d = msp_pkg::ST_IDLE;
      end
    endcase
  end

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o))
    else $error("result without accepted word");

  a_one_result_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> result_valid_o)
    else $error("accepted word gave no result");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LINK_NULL)
    else $error("fill count beyond capacity");

  a_push_moves_free_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (op_q == msp_pkg::OP_PUSH)) |=> (free_head_q != $past(slot_q)))
    else $error("pushed slot still heads the free list");

  a_pop_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (op_q == msp_pkg::OP_POP)) |=> (free_head_q == $past(slot_q)))
    else $error("popped slot not returned to free list");

endmodule

// ===== dv/multi_stack_shared_pool_tb.sv =====
// Testbench for the multi-stack shared-pool block: directed and random push/pop words.
`timescale 1ns / 1ps

module multi_stack_shared_pool_tb;

  localparam int NUM_STACKS = msp_pkg::NUM_STACKS_DEF;
  localparam int CAPACITY   = msp_pkg::CAPACITY_DEF;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W     = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAPACITY);
  localparam int RANDOM_WORDS = 1200;

  typedef struct {
    msp_pkg::op_e                       op;
    logic [msp_pkg::SEL_W-1:0]          sel;
    logic [msp_pkg::DATA_W-1:0]         value;
    bit                                 wait_idle;
  } stack_cmd_t;

  typedef struct {
    logic [msp_pkg::DATA_W-1:0] pop_value;
    msp_pkg::status_e           status;
  } stack_result_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          start_i        = 1'b0;
  logic                          operation_i    = 1'b0;
  logic [msp_pkg::SEL_W-1:0]     stack_select_i = '0;
  logic [msp_pkg::DATA_W-1:0]    push_value_i   = '0;
  logic                          busy_o;
  logic                          result_valid_o;
  logic [msp_pkg::DATA_W-1:0]    pop_value_o;
  logic [msp_pkg::STATUS_W-1:0]  status_o;

  stack_cmd_t    cmd_q[$];
  stack_result_t expected_q[$];

  logic [msp_pkg::DATA_W-1:0] slot_data [CAPACITY];
  logic [LINK_W-1:0]          slot_link [CAPACITY];
  logic [LINK_W-1:0]          stack_top [NUM_STACKS];
  logic [LINK_W-1:0]          free_head;

  int errors     = 0;
  int burst_left = 1;
  int gap_left   = 0;

  multi_stack_shared_pool dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .pop_value_o    (pop_value_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [msp_pkg::DATA_W-1:0] got,
                                 logic [msp_pkg::DATA_W-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void predict_stack_op(msp_pkg::op_e op, logic [msp_pkg::SEL_W-1:0] sel,
                                           logic [msp_pkg::DATA_W-1:0] value);
    stack_result_t r;
    logic [LINK_W-1:0] slot;
    r.pop_value = '0;
    r.status    = msp_pkg::STATUS_OK;
    if (op == msp_pkg::OP_PUSH) begin
      slot = free_head;
      if (sel >= NUM_STACKS || slot >= CAPACITY) begin
        r.status = msp_pkg::STATUS_OVERFLOW;
      end else begin
        free_head                   = slot_link[slot[ADDR_W-1:0]];
        slot_link[slot[ADDR_W-1:0]] = stack_top[sel];
        stack_top[sel]              = slot;
        slot_data[slot[ADDR_W-1:0]] = value;
      end
    end else if (sel >= NUM_STACKS || stack_top[sel] >= CAPACITY) begin
      r.status = msp_pkg::STATUS_UNDERFLOW;
    end else begin
      slot                        = stack_top[sel];
      stack_top[sel]              = slot_link[slot[ADDR_W-1:0]];
      slot_link[slot[ADDR_W-1:0]] = free_head;
      free_head                   = slot;
      r.pop_value                 = slot_data[slot[ADDR_W-1:0]];
    end
    expected_q.push_back(r);
  endfunction

  function automatic stack_cmd_t make_cmd(msp_pkg::op_e op, int sel,
                                          logic [msp_pkg::DATA_W-1:0] value);
    stack_cmd_t c;
    c.op        = op;
    c.sel       = msp_pkg::SEL_W'(sel);
    c.value     = value;
    c.wait_idle = 1'b0;
    return c;
  endfunction

  function automatic stack_cmd_t random_cmd(int push_pct);
    logic [msp_pkg::DATA_W-1:0] value;
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      2:       value = msp_pkg::DATA_W'(1) << $urandom_range(0, msp_pkg::DATA_W - 1);
      default: value = $urandom;
    endcase
    return make_cmd(($urandom_range(0, 99) < push_pct) ? msp_pkg::OP_PUSH : msp_pkg::OP_POP,
                    $urandom_range(0, NUM_STACKS - 1), value);
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_proc
    logic taken;
    logic drained;
    if (rst_ni) begin
      taken   = start_i && !busy_o;
      drained = expected_q.size() <= (result_valid_o ? 1 : 0);
      if (taken) begin
        predict_stack_op(msp_pkg::op_e'(operation_i), stack_select_i, push_value_i);
        void'(cmd_q.pop_front());
        drained = 1'b0;
      end
      if (start_i && !taken) begin
        start_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_q.size() > 0 && (!cmd_q[0].wait_idle || drained)) begin
        start_i        <= 1'b1;
        operation_i    <= cmd_q[0].op;
        stack_select_i <= cmd_q[0].sel;
        push_value_i   <= cmd_q[0].value;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_proc
    stack_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", pop_value_o, '0);
      end else begin
        want = expected_q.pop_front();
        if (pop_value_o !== want.pop_value)
          report_mismatch("pop_value", pop_value_o, want.pop_value);
        if (status_o !== want.status)
          report_mismatch("status", msp_pkg::DATA_W'(status_o),
                          msp_pkg::DATA_W'(want.status));
      end
    end
  end

  initial begin : stim_proc
    stack_cmd_t c;
    int push_pct;
    int phase_len;
    int count;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data[i] = '0;
      slot_link[i] = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : LINK_NULL;
    end
    for (int s = 0; s < NUM_STACKS; s++) stack_top[s] = LINK_NULL;
    free_head = '0;

    // pop every empty stack, push extremes, then unwind past empty
    for (int s = 0; s < NUM_STACKS; s++) cmd_q.push_back(make_cmd(msp_pkg::OP_POP, s, '1));
    cmd_q.push_back(make_cmd(msp_pkg::OP_PUSH, 0, 32'h0000_0000));
    cmd_q.push_back(make_cmd(msp_pkg::OP_PUSH, 0, 32'hFFFF_FFFF));
    cmd_q.push_back(make_cmd(msp_pkg::OP_PUSH, 1, 32'hAAAA_AAAA));
    cmd_q.push_back(make_cmd(msp_pkg::OP_PUSH, 2, 32'h5555_5555));
    cmd_q.push_back(make_cmd(msp_pkg::OP_PUSH, 3, 32'h8000_0000));
    cmd_q.push_back(make_cmd(msp_pkg::OP_PUSH, 3, 32'h0000_0001));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 3, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 3, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 3, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 0, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 0, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 0, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 1, '0));
    cmd_q.push_back(make_cmd(msp_pkg::OP_POP, 2, '0));

    // fill past full, drain past empty, and mix
    count = 0;
    while (count < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0:       begin push_pct = 90; phase_len = $urandom_range(90, 160); end
        1:       begin push_pct = 10; phase_len = $urandom_range(90, 160); end
        default: begin push_pct = 50; phase_len = $urandom_range(40, 100); end
      endcase
      for (int k = 0; k < phase_len && count < RANDOM_WORDS; k++) begin
        c = random_cmd(push_pct);
        c.wait_idle = (k == 0) && (count == 0 || $urandom_range(0, 2) == 0);
        cmd_q.push_back(c);
        count++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #500us;
    $display("Test completed with failures");
    $finish;
  end

endmodule
